// File: rtl/core/mio0_pkg.sv
// ----------------------------------------------------------------------------
// MIO0 decompressor package
// Shared widths, codes and the structs that pass between the sequencer,
// the history RAM and the top level.
// ----------------------------------------------------------------------------
package mio0_pkg;

  // History ring depth is 2**HistAddrW bytes.
  localparam int unsigned HistAddrW = 12;
  // Width of the byte counters.
  localparam int unsigned CountW = 24;
  // Width of the per-token run counter (up to 18 bytes).
  localparam int unsigned RunW = 5;

  // Shortest back-reference copy.
  localparam logic [RunW-1:0] MinMatchLen = 5'd3;

  // Layout bit codes.
  localparam logic OpPair    = 1'b0;
  localparam logic OpLiteral = 1'b1;

  // Access request toward the history RAM.
  typedef struct packed {
    logic                 rd_en;
    logic [HistAddrW-1:0] rd_addr;
    logic                 wr_en;
    logic [HistAddrW-1:0] wr_addr;
    logic [7:0]           wr_data;
  } hist_req_t;

  // One decompressed byte with its flags.
  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       eoo;
    logic       bad;
  } byte_res_t;

endpackage

// File: rtl/core/mio0_hist_ram.sv
// ----------------------------------------------------------------------------
// MIO0 history RAM
// Single-write, single-read ring of produced bytes with registered read data.
// ----------------------------------------------------------------------------
module mio0_hist_ram (
  input  logic                clk_i,
  input  mio0_pkg::hist_req_t req_i,
  output logic [7:0]          rd_data_o
);

  localparam int unsigned Depth = 1 << mio0_pkg::HistAddrW;

  logic [7:0] mem_q [Depth];
  logic [7:0] rd_data_q;

  // Contents are undefined until written, so there is no reset here.
  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem_q[req_i.wr_addr] <= req_i.wr_data;
    end
    if (req_i.rd_en) begin
      rd_data_q <= mem_q[req_i.rd_addr];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// File: rtl/core/mio0_copy_seq.sv
// ----------------------------------------------------------------------------
// MIO0 copy sequencer
// Steps one token out byte by byte: one history read, one history write and
// one counter update per cycle, holding while the output register is full.
// ----------------------------------------------------------------------------
module mio0_copy_seq (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic                                 op_i,
  input  logic [7:0]                           literal_byte_i,
  input  logic [15:0]                          pair_word_i,
  input  logic [mio0_pkg::CountW-1:0]          total_length_i,
  input  logic                                 stall_i,
  input  logic [7:0]                           rd_data_i,
  output mio0_pkg::hist_req_t                  hist_req_o,
  output logic                                 emit_o,
  output mio0_pkg::byte_res_t                  res_o
);

  localparam int unsigned AW = mio0_pkg::HistAddrW;
  localparam int unsigned CW = mio0_pkg::CountW;
  localparam int unsigned RW = mio0_pkg::RunW;

  typedef enum logic {
    StIdle,
    StEmit
  } state_e;

  state_e        state_q;
  logic [AW-1:0] wp_q;
  logic [CW-1:0] count_q;
  logic [CW-1:0] left_q;
  logic [RW-1:0] run_q;
  logic [AW:0]   offset_q;
  logic [AW-1:0] src_q;
  logic          is_lit_q;
  logic [7:0]    lit_q;
  logic          bad_q;
  logic [7:0]    prev_q;

  logic          accept;
  logic          has_room;
  logic [AW:0]   offset_new;
  logic          src_avail;
  logic [7:0]    byte_val;
  logic          emit;
  logic          last_byte;

  // Token intake: only while idle.
  assign in_ready_o = (state_q == StIdle);
  assign accept     = in_valid_i && in_ready_o;
  assign has_room   = (total_length_i > count_q);
  assign offset_new = {1'b0, pair_word_i[AW-1:0]} + {{AW{1'b0}}, 1'b1};

  // Byte selection: literal, zero for a source before the first byte,
  // the byte just produced for distance one, otherwise the RAM read.
  assign src_avail = ({{(CW-AW-1){1'b0}}, offset_q} <= count_q);

  always_comb begin
    if (is_lit_q) begin
      byte_val = lit_q;
    end else if (!src_avail) begin
      byte_val = 8'h00;
    end else if (offset_q == {{AW{1'b0}}, 1'b1}) begin
      byte_val = prev_q;
    end else begin
      byte_val = rd_data_i;
    end
  end

  assign emit      = (state_q == StEmit) && !stall_i;
  assign last_byte = is_lit_q || (run_q == {{(RW-1){1'b0}}, 1'b1}) ||
                     (left_q == {{(CW-1){1'b0}}, 1'b1});

  // History accesses: read the next source while writing the current byte.
  always_comb begin
    hist_req_o.rd_en   = accept || (emit && !last_byte);
    hist_req_o.rd_addr = accept ? (wp_q - pair_word_i[AW-1:0] - {{(AW-1){1'b0}}, 1'b1})
                                : (src_q + {{(AW-1){1'b0}}, 1'b1});
    hist_req_o.wr_en   = emit;
    hist_req_o.wr_addr = wp_q;
    hist_req_o.wr_data = byte_val;
  end

  assign emit_o     = emit;
  assign res_o.data = byte_val;
  assign res_o.last = last_byte;
  assign res_o.eoo  = (left_q == {{(CW-1){1'b0}}, 1'b1});
  assign res_o.bad  = bad_q;

  // Sequencer state and per-token registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      wp_q     <= '0;
      count_q  <= '0;
      left_q   <= '0;
      run_q    <= '0;
      offset_q <= '0;
      src_q    <= '0;
      is_lit_q <= 1'b0;
      lit_q    <= '0;
      bad_q    <= 1'b0;
      prev_q   <= '0;
    end else begin
      case (state_q)
        StIdle: begin
          if (accept && has_room) begin
            state_q  <= StEmit;
            left_q   <= total_length_i - count_q;
            is_lit_q <= (op_i == mio0_pkg::OpLiteral);
            lit_q    <= literal_byte_i;
            offset_q <= offset_new;
            src_q    <= hist_req_o.rd_addr;
            if (op_i == mio0_pkg::OpLiteral) begin
              run_q <= {{(RW-1){1'b0}}, 1'b1};
              bad_q <= 1'b0;
            end else begin
              run_q <= {1'b0, pair_word_i[15:12]} + mio0_pkg::MinMatchLen;
              bad_q <= ({{(CW-AW-1){1'b0}}, offset_new} > count_q);
            end
          end
        end
        StEmit: begin
          if (emit) begin
            wp_q    <= wp_q + {{(AW-1){1'b0}}, 1'b1};
            count_q <= count_q + {{(CW-1){1'b0}}, 1'b1};
            left_q  <= left_q - {{(CW-1){1'b0}}, 1'b1};
            run_q   <= run_q - {{(RW-1){1'b0}}, 1'b1};
            src_q   <= src_q + {{(AW-1){1'b0}}, 1'b1};
            prev_q  <= byte_val;
            if (last_byte) begin
              state_q <= StIdle;
            end
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

endmodule

// File: rtl/core/mio0_lz_decompressor.sv
// ----------------------------------------------------------------------------
// MIO0 LZ decompressor
// Token-level MIO0 decoder: literal and back-reference tokens in, one
// decompressed byte per output transaction.
// ----------------------------------------------------------------------------
// Usage:
// - Input channel (in_valid_i/in_ready_o) takes one token per transaction:
//   op_i selects a literal byte or a 16-bit back-reference pair word.
// - Output channel (out_valid_o/out_ready_i) delivers one byte per
//   transaction with last_of_token, end_of_output and bad_reference flags.
// - Config channel (cfg_valid_i/cfg_ready_o) writes total_length; always
//   ready; the user must write it only while idle, the block does not check.
// - A token first takes a setup step for the first history read, then emits
//   one byte per cycle while the receiver does not stall, with one history
//   write and one output register load per byte. A token arriving after
//   total_length bytes emits nothing and leaves the sequencer idle.
// - The first byte is loaded into the output register from StEmit.
// - When the receiver stalls, the sequencer freezes with the byte held in
//   the output register; no byte is dropped or repeated.
// - Reset clears the counters, the write pointer and total_length. The
//   4096-byte history is not cleared; every legal read hits a written entry.
// ----------------------------------------------------------------------------
module mio0_lz_decompressor (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [23:0] cfg_total_length_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        op_i,
  input  logic [7:0]  literal_byte_i,
  input  logic [15:0] pair_word_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  out_byte_o,
  output logic        last_of_token_o,
  output logic        end_of_output_o,
  output logic        bad_reference_o
);

  logic [mio0_pkg::CountW-1:0] total_length_q;
  logic                        out_valid_q;
  mio0_pkg::byte_res_t         out_res_q;
  logic                        stall;
  logic                        emit;
  mio0_pkg::byte_res_t         res;
  mio0_pkg::hist_req_t         hist_req;
  logic [7:0]                  rd_data;

  // Configuration register.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_length_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      total_length_q <= cfg_total_length_i;
    end
  end

  // The sequencer holds while a byte waits in the output register.
  assign stall = out_valid_q && !out_ready_i;

  mio0_copy_seq u_seq (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .op_i           (op_i),
    .literal_byte_i (literal_byte_i),
    .pair_word_i    (pair_word_i),
    .total_length_i (total_length_q),
    .stall_i        (stall),
    .rd_data_i      (rd_data),
    .hist_req_o     (hist_req),
    .emit_o         (emit),
    .res_o          (res)
  );

  mio0_hist_ram u_hist (
    .clk_i     (clk_i),
    .req_i     (hist_req),
    .rd_data_o (rd_data)
  );

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      out_res_q   <= '0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
      out_res_q   <= res;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign out_byte_o      = out_res_q.data;
  assign last_of_token_o = out_res_q.last;
  assign end_of_output_o = out_res_q.eoo;
  assign bad_reference_o = out_res_q.bad;

`ifndef SYNTHESIS
  // A new byte never overwrites one the receiver has not taken.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(emit && stall))
    else $error("byte emitted while output register stalled");

  // The byte that completes the output also closes its token.
  a_end_closes_token: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_res_q.eoo) |-> out_res_q.last)
    else $error("end of output without last of token");

  // After the final byte of a token the sequencer is ready for the next one.
  a_ready_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && res.last) |=> in_ready_o)
    else $error("sequencer not idle after last byte of token");
`endif

endmodule

// File: sim/mio0_lz_decompressor_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MIO0 LZ decompressor checker
// Watches the configuration, token and byte channels of the decompressor.
// Every accepted token is expanded into the bytes it should produce, using a
// private copy of the history ring, the write pointer, the byte count and
// total_length. Every accepted output byte is compared with the oldest
// expected byte. The error count, the number of bytes still owed and the
// running byte count are handed to the testbench top.
// ----------------------------------------------------------------------------
module mio0_lz_decompressor_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [23:0] cfg_total_length_i,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic        op_i,
  input  logic [7:0]  literal_byte_i,
  input  logic [15:0] pair_word_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [7:0]  out_byte_i,
  input  logic        last_of_token_i,
  input  logic        end_of_output_i,
  input  logic        bad_reference_i,
  output int          err_count_o,
  output int          pending_o,
  output logic [23:0] produced_o
);

  // Private copy of the decoder state.
  logic [7:0]                     hist_mem [2**mio0_pkg::HistAddrW];
  logic [mio0_pkg::HistAddrW-1:0] wr_ptr    = '0;
  logic [mio0_pkg::CountW-1:0]    made      = '0;
  logic [mio0_pkg::CountW-1:0]    total_len = '0;

  // Bytes predicted but not yet seen on the output channel.
  mio0_pkg::byte_res_t            owed_bytes [$];
  int                             errors    = 0;

  initial begin
    err_count_o = 0;
    pending_o   = 0;
    produced_o  = '0;
  end

  // Append one byte to the history and queue it as an expected output.
  task automatic store_byte(input logic [7:0] b, input logic wild, input logic fin);
    mio0_pkg::byte_res_t r;
    hist_mem[wr_ptr] = b;
    wr_ptr = wr_ptr + 1'b1;
    made   = made + 1'b1;
    r.data = b;
    r.last = fin;
    r.eoo  = (made == total_len);
    r.bad  = wild;
    owed_bytes.push_back(r);
  endtask

  // Expand one token into the bytes it produces.
  task automatic expand_token(input logic kind, input logic [7:0] lit,
                              input logic [15:0] word);
    logic [12:0]                 back;
    logic [mio0_pkg::RunW-1:0]   run;
    logic                        wild;
    logic [7:0]                  b;
    logic [mio0_pkg::RunW-1:0]   i;
    back = {1'b0, word[11:0]} + 13'd1;
    run  = {1'b0, word[15:12]} + mio0_pkg::MinMatchLen;
    wild = ({11'd0, back} > made);
    i    = '0;
    // Once the configured length is reached, tokens are swallowed.
    if (made >= total_len) return;
    if (kind == mio0_pkg::OpLiteral) begin
      store_byte(lit, 1'b0, 1'b1);
    end else begin
      // A copy stops early at the configured length; a source ahead of
      // the first produced byte yields a zero.
      while (i < run && made < total_len) begin
        b = ({11'd0, back} <= made) ? hist_mem[wr_ptr - back[11:0]] : 8'h00;
        store_byte(b, wild, (i == run - 1'b1) || (made + 1'b1 == total_len));
        i = i + 1'b1;
      end
    end
  endtask

  // Compare one output transaction with the oldest expected byte.
  task automatic check_byte();
    mio0_pkg::byte_res_t got;
    mio0_pkg::byte_res_t want;
    got = {out_byte_i, last_of_token_i, end_of_output_i, bad_reference_i};
    if (owed_bytes.size() == 0) begin
      errors++;
      if (errors <= 10) begin
        $display("ERROR: unexpected byte %02h last %0b eoo %0b bad %0b at %0t",
                 got.data, got.last, got.eoo, got.bad, $realtime);
      end
    end else begin
      want = owed_bytes.pop_front();
      if (got !== want) begin
        errors++;
        if (errors <= 10) begin
          $display("ERROR: byte mismatch at %0t: expected %02h/%0b/%0b/%0b, got %02h/%0b/%0b/%0b",
                   $realtime, want.data, want.last, want.eoo, want.bad,
                   got.data, got.last, got.eoo, got.bad);
        end
      end
    end
  endtask

  // Sample all channels at the clock edge; publish status for the top.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr    = '0;
      made      = '0;
      total_len = '0;
      owed_bytes.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) total_len = cfg_total_length_i;
      if (in_valid_i && in_ready_i) expand_token(op_i, literal_byte_i, pair_word_i);
      if (out_valid_i && out_ready_i) check_byte();
    end
    err_count_o <= errors;
    pending_o   <= owed_bytes.size();
    produced_o  <= made;
  end

endmodule

// File: sim/mio0_lz_decompressor_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MIO0 LZ decompressor testbench
// Drives tokens and total_length writes into the decompressor and applies
// random back-pressure on the byte channel. A directed part covers literal
// extremes, overlapping and maximum-length copies, bad references, copies
// cut at the configured length and swallowed tokens; a random part then
// wraps the history ring. The checker beside the block judges every byte.
// ----------------------------------------------------------------------------
module mio0_lz_decompressor_tb;

  localparam int WatchdogLimit = 2000;
  localparam int SettleCycles  = 24;

  logic        clk_i              = 1'b0;
  logic        rst_ni             = 1'b0;
  logic        cfg_valid_i        = 1'b0;
  logic        cfg_ready_o;
  logic [23:0] cfg_total_length_i = '0;
  logic        in_valid_i         = 1'b0;
  logic        in_ready_o;
  logic        op_i               = mio0_pkg::OpLiteral;
  logic [7:0]  literal_byte_i     = '0;
  logic [15:0] pair_word_i        = '0;
  logic        out_valid_o;
  logic        out_ready_i        = 1'b1;
  logic [7:0]  out_byte_o;
  logic        last_of_token_o;
  logic        end_of_output_o;
  logic        bad_reference_o;

  int          err_count;
  int          pending;
  logic [23:0] produced;

  int          stall_left  = 0;
  int          calm_left   = 0;
  int          idle_cycles = 0;
  bit          calm_end    = 1'b0;

  always #5 clk_i = ~clk_i;

  mio0_lz_decompressor u_top (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_ready_o        (cfg_ready_o),
    .cfg_total_length_i (cfg_total_length_i),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .op_i               (op_i),
    .literal_byte_i     (literal_byte_i),
    .pair_word_i        (pair_word_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .out_byte_o         (out_byte_o),
    .last_of_token_o    (last_of_token_o),
    .end_of_output_o    (end_of_output_o),
    .bad_reference_o    (bad_reference_o)
  );

  mio0_lz_decompressor_checker u_checker (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_ready_i        (cfg_ready_o),
    .cfg_total_length_i (cfg_total_length_i),
    .in_valid_i         (in_valid_i),
    .in_ready_i         (in_ready_o),
    .op_i               (op_i),
    .literal_byte_i     (literal_byte_i),
    .pair_word_i        (pair_word_i),
    .out_valid_i        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .out_byte_i         (out_byte_o),
    .last_of_token_i    (last_of_token_o),
    .end_of_output_i    (end_of_output_o),
    .bad_reference_i    (bad_reference_o),
    .err_count_o        (err_count),
    .pending_o          (pending),
    .produced_o         (produced)
  );

  // Byte channel back-pressure: short stall bursts, calm stretches, and
  // none at all once the final part of the run begins.
  always @(posedge clk_i) begin
    if (calm_end || calm_left > 0) begin
      out_ready_i <= 1'b1;
      if (calm_left > 0) calm_left <= calm_left - 1;
    end else if (stall_left > 0) begin
      out_ready_i <= 1'b0;
      stall_left  <= stall_left - 1;
    end else if ($urandom_range(0, 3) == 0) begin
      out_ready_i <= 1'b0;
      stall_left  <= $urandom_range(0, 2);
    end else begin
      out_ready_i <= 1'b1;
      if ($urandom_range(0, 63) == 0) calm_left <= $urandom_range(20, 80);
    end
  end

  // Watchdog: too many cycles without any transaction ends the run.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WatchdogLimit) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Write total_length through the configuration channel.
  task automatic write_total(input logic [23:0] value);
    cfg_valid_i        <= 1'b1;
    cfg_total_length_i <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Offer one token, optionally after a short gap, and wait for acceptance.
  task automatic send_token(input logic kind, input logic [7:0] lit,
                            input logic [15:0] word, input bit gaps);
    if (gaps && $urandom_range(0, 2) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    op_i           <= kind;
    literal_byte_i <= lit;
    pair_word_i    <= word;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  // Random token: mostly copies, half at maximum length, with offsets that
  // are mostly short or inside the bytes produced so far.
  task automatic send_rand(input bit gaps);
    logic       kind;
    logic [3:0] len;
    logic [11:0] off;
    int         span;
    kind = ($urandom_range(0, 99) < 30) ? mio0_pkg::OpLiteral : mio0_pkg::OpPair;
    len  = $urandom_range(0, 1) ? 4'hF : 4'($urandom_range(0, 15));
    span = (produced > 24'd4096) ? 4096 : int'(produced);
    case ($urandom_range(0, 9))
      0, 1, 2, 3: off = 12'($urandom_range(0, 3));
      9:          off = 12'($urandom);
      default:    off = (span > 0) ? 12'($urandom_range(0, span - 1)) : 12'd0;
    endcase
    send_token(kind, 8'($urandom), {len, off}, gaps);
  endtask

  // Hold off the sender until every expected byte has arrived, then give
  // the block time to finish any token that produced nothing.
  task automatic settle();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  initial begin
    int i;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Zero length: every token is swallowed.
    write_total(24'd0);
    send_token(mio0_pkg::OpLiteral, 8'h11, 16'h0000, 1'b0);
    send_token(mio0_pkg::OpPair, 8'h00, 16'h1234, 1'b0);
    settle();

    // Directed tokens against a 60-byte output.
    write_total(24'd60);
    // Copy from an empty history: all zeros, flagged bad.
    send_token(mio0_pkg::OpPair, 8'hFF, 16'h0000, 1'b1);
    send_token(mio0_pkg::OpLiteral, 8'hFF, 16'h0000, 1'b1);
    send_token(mio0_pkg::OpLiteral, 8'h00, 16'hFFFF, 1'b1);
    send_token(mio0_pkg::OpLiteral, 8'hA5, 16'h5A5A, 1'b1);
    send_token(mio0_pkg::OpLiteral, 8'h5A, 16'hFFFF, 1'b1);
    // Reference that starts behind the first byte and then catches up.
    send_token(mio0_pkg::OpPair, 8'h00, 16'h3008, 1'b1);
    // Longest overlapping copy with offset one.
    send_token(mio0_pkg::OpPair, 8'hC3, 16'hF000, 1'b1);
    send_token(mio0_pkg::OpPair, 8'h00, 16'h1002, 1'b1);
    // Largest offset while history is short: bad reference.
    send_token(mio0_pkg::OpPair, 8'h00, 16'h0FFF, 1'b1);
    send_token(mio0_pkg::OpLiteral, 8'h81, 16'h0000, 1'b1);
    send_token(mio0_pkg::OpPair, 8'h7F, 16'hFFFF, 1'b1);
    // This copy crosses the configured length and is cut short.
    send_token(mio0_pkg::OpPair, 8'h00, 16'h5004, 1'b1);
    send_token(mio0_pkg::OpLiteral, 8'h7E, 16'h0000, 1'b1);
    settle();

    // Length lowered below the count: nothing comes out.
    write_total(24'd20);
    send_token(mio0_pkg::OpLiteral, 8'h3C, 16'h0000, 1'b0);
    send_token(mio0_pkg::OpPair, 8'h00, 16'h2001, 1'b0);
    settle();

    // Random tokens with no practical length limit; this wraps the ring.
    write_total(24'hFFFFFF);
    for (i = 0; i < 400; i++) begin
      if (i == 150) settle();
      send_rand((i / 40) % 3 != 2);
    end
    settle();

    // Final stretch without idling, ending at a fresh length limit.
    write_total(produced + 24'd150);
    calm_end <= 1'b1;
    for (i = 0; i < 40; i++) send_rand(1'b0);
    settle();

    if (err_count == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
